/* hw/rtl/dtq_pkg.sv */
// Shared types and constants for the deadline timer queue.
// Used by the controller, the datapath, the top level and the checker.
package dtq_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned BurstMax   = 16;
  localparam int unsigned BurstW     = $clog2(BurstMax);

  localparam int unsigned TimeW  = 48;
  localparam int unsigned IdW    = 32;
  localparam int unsigned TagW   = 16;
  localparam int unsigned DelayW = 20;

  localparam logic KindSchedule = 1'b0;
  localparam logic KindTick     = 1'b1;
  localparam logic StatusOk     = 1'b0;
  localparam logic StatusFull   = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StSched,
    StTick,
    StScan,
    StEmit
  } dtq_state_e;

  typedef struct packed {
    logic [TimeW-1:0] deadline;
    logic [IdW-1:0]   id;
    logic [TagW-1:0]  tag;
  } dtq_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic sched;
    logic tick;
    logic scan_start;
    logic emit;
  } dtq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic kind;
    logic out_free;
    logic scan_done;
    logic found;
    logic last;
  } dtq_sts_t;

endpackage

/* hw/rtl/deadline_timer_queue.sv */
// Top level of the deadline timer queue: controller plus datapath.
// Depends on dtq_pkg, dtq_ctrl and dtq_datapath.
//
// A table of dtq_pkg::TableDepth pending timers kept against a 48-bit tick
// counter. A schedule beat (kind 0) stores a timer due at now plus delay in the
// lowest free slot and answers with one beat carrying its 32-bit sequence id,
// or with status 1 and id 0 when the table is full (the id is then not used
// up). A tick beat (kind 1) advances time by one, then releases every timer
// now due, earliest deadline first with the lower id winning ties, one beat
// per timer with last set on the final one; at most 16 timers leave per tick
// and a tick with nothing due gives no beat at all. Items are handled one at a
// time. The length of a tick is set by the table scan: each search walks the
// whole table through the store's single read port, one entry per cycle. A
// quiet tick runs one search, and a tick that releases timers runs one search
// per timer and also waits while the output side holds ready low. The result
// sits in an output register, so the input side is ready again as soon as the
// last beat of an item is loaded there.
module deadline_timer_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       kind_i,
  input  logic [dtq_pkg::DelayW-1:0] delay_i,
  input  logic [dtq_pkg::TagW-1:0]   tag_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       result_kind_o,
  output logic [dtq_pkg::IdW-1:0]    timer_id_o,
  output logic [dtq_pkg::TagW-1:0]   fired_tag_o,
  output logic                       status_o,
  output logic                       last_o
);

  // Commands flow from the controller, status flows back from the datapath.
  dtq_pkg::dtq_cmd_t cmd;
  dtq_pkg::dtq_sts_t sts;

  dtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dtq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (kind_i),
    .delay_i       (delay_i),
    .tag_i         (tag_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .timer_id_o    (timer_id_o),
    .fired_tag_o   (fired_tag_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule

/* hw/rtl/dtq_ctrl.sv */
// Sequencing state machine of the deadline timer queue.
// Depends on dtq_pkg for the state enum and the command and status structs.
module dtq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dtq_pkg::dtq_sts_t sts_i,
  output dtq_pkg::dtq_cmd_t cmd_o
);

  dtq_pkg::dtq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtq_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dtq_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = dtq_pkg::StSched;
        end
      end
      dtq_pkg::StSched: begin
        if (sts_i.kind == dtq_pkg::KindTick) begin
          state_d = dtq_pkg::StTick;
        end else if (sts_i.out_free) begin
          state_d = dtq_pkg::StIdle;
        end
      end
      dtq_pkg::StTick: begin
        state_d = dtq_pkg::StScan;
      end
      dtq_pkg::StScan: begin
        if (sts_i.scan_done) begin
          state_d = sts_i.found ? dtq_pkg::StEmit : dtq_pkg::StIdle;
        end
      end
      dtq_pkg::StEmit: begin
        if (sts_i.out_free) begin
          state_d = sts_i.last ? dtq_pkg::StIdle : dtq_pkg::StScan;
        end
      end
      default: begin
        state_d = dtq_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dtq_pkg::StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      dtq_pkg::StSched: begin
        cmd_o.sched = (sts_i.kind == dtq_pkg::KindSchedule) && sts_i.out_free;
      end
      dtq_pkg::StTick: begin
        cmd_o.tick       = 1'b1;
        cmd_o.scan_start = 1'b1;
      end
      dtq_pkg::StEmit: begin
        cmd_o.emit       = sts_i.out_free;
        cmd_o.scan_start = sts_i.out_free && !sts_i.last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/dtq_datapath.sv */
// Timer table, time and sequence counters, scan compare and result register.
// Depends on dtq_pkg for widths, the entry layout and the command structs.
module dtq_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dtq_pkg::dtq_cmd_t          cmd_i,
  output dtq_pkg::dtq_sts_t          sts_o,
  input  logic                       kind_i,
  input  logic [dtq_pkg::DelayW-1:0] delay_i,
  input  logic [dtq_pkg::TagW-1:0]   tag_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       result_kind_o,
  output logic [dtq_pkg::IdW-1:0]    timer_id_o,
  output logic [dtq_pkg::TagW-1:0]   fired_tag_o,
  output logic                       status_o,
  output logic                       last_o
);

  localparam logic [dtq_pkg::IdxW-1:0] LastIdx = dtq_pkg::IdxW'(dtq_pkg::TableDepth - 1);

  // Entry store and its valid bits.
  dtq_pkg::dtq_entry_t            mem [dtq_pkg::TableDepth];
  logic [dtq_pkg::TableDepth-1:0] valid_q;

  // Captured input beat.
  logic                       kind_q;
  logic [dtq_pkg::DelayW-1:0] delay_q;
  logic [dtq_pkg::TagW-1:0]   tag_q;

  logic [dtq_pkg::TimeW-1:0] time_q;
  logic [dtq_pkg::IdW-1:0]   seq_q;

  // Scan pipeline: read stage, then compare stage.
  logic                      rd_busy_q;
  logic [dtq_pkg::IdxW-1:0]  rd_ptr_q;
  logic                      cmp_vld_q;
  logic [dtq_pkg::IdxW-1:0]  cmp_idx_q;
  dtq_pkg::dtq_entry_t       rd_q;

  logic                      best_found_q;
  logic [dtq_pkg::IdxW-1:0]  best_idx_q;
  dtq_pkg::dtq_entry_t       best_q;
  logic [1:0]                due_cnt_q;
  logic [dtq_pkg::BurstW-1:0] burst_cnt_q;

  // Output register.
  logic                      out_valid_q;
  logic                      out_kind_q;
  logic [dtq_pkg::IdW-1:0]   out_id_q;
  logic [dtq_pkg::TagW-1:0]  out_tag_q;
  logic                      out_status_q;
  logic                      out_last_q;

  logic                      full;
  logic [dtq_pkg::IdxW-1:0]  free_idx;
  logic                      out_free;
  logic                      due;
  logic                      better;
  logic                      last;

  assign full = &valid_q;

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = dtq_pkg::TableDepth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = dtq_pkg::IdxW'(i);
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign due      = cmp_vld_q && valid_q[cmp_idx_q] && (rd_q.deadline <= time_q);
  assign better   = !best_found_q || (rd_q.deadline < best_q.deadline) ||
                    ((rd_q.deadline == best_q.deadline) && (rd_q.id < best_q.id));
  assign last     = (due_cnt_q == 2'd1) ||
                    (burst_cnt_q == dtq_pkg::BurstW'(dtq_pkg::BurstMax - 1));

  assign sts_o.kind      = kind_q;
  assign sts_o.out_free  = out_free;
  assign sts_o.scan_done = !rd_busy_q && !cmp_vld_q;
  assign sts_o.found     = best_found_q;
  assign sts_o.last      = last;

  // Store writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sched && !full) begin
      mem[free_idx] <= '{deadline: time_q + dtq_pkg::TimeW'(delay_q), id: seq_q, tag: tag_q};
    end
    if (rd_busy_q) begin
      rd_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      delay_q <= delay_i;
      tag_q   <= tag_i;
    end
    if (rd_busy_q) begin
      cmp_idx_q <= rd_ptr_q;
    end
    if (due && better) begin
      best_idx_q <= cmp_idx_q;
      best_q     <= rd_q;
    end
    if (cmd_i.sched) begin
      out_kind_q   <= dtq_pkg::KindSchedule;
      out_id_q     <= full ? '0 : seq_q;
      out_tag_q    <= '0;
      out_status_q <= full ? dtq_pkg::StatusFull : dtq_pkg::StatusOk;
      out_last_q   <= 1'b1;
    end else if (cmd_i.emit) begin
      out_kind_q   <= dtq_pkg::KindTick;
      out_id_q     <= best_q.id;
      out_tag_q    <= best_q.tag;
      out_status_q <= dtq_pkg::StatusOk;
      out_last_q   <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      time_q       <= '0;
      seq_q        <= dtq_pkg::IdW'(1);
      rd_busy_q    <= 1'b0;
      rd_ptr_q     <= '0;
      cmp_vld_q    <= 1'b0;
      best_found_q <= 1'b0;
      due_cnt_q    <= '0;
      burst_cnt_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.sched && !full) begin
        valid_q[free_idx] <= 1'b1;
        seq_q             <= seq_q + dtq_pkg::IdW'(1);
      end
      if (cmd_i.tick) begin
        time_q      <= time_q + dtq_pkg::TimeW'(1);
        burst_cnt_q <= '0;
      end
      if (cmd_i.emit) begin
        valid_q[best_idx_q] <= 1'b0;
        burst_cnt_q         <= burst_cnt_q + dtq_pkg::BurstW'(1);
      end

      if (cmd_i.scan_start) begin
        rd_busy_q    <= 1'b1;
        rd_ptr_q     <= '0;
        best_found_q <= 1'b0;
        due_cnt_q    <= '0;
      end else if (rd_busy_q) begin
        rd_ptr_q <= rd_ptr_q + dtq_pkg::IdxW'(1);
        if (rd_ptr_q == LastIdx) begin
          rd_busy_q <= 1'b0;
        end
      end
      cmp_vld_q <= rd_busy_q && !cmd_i.scan_start;
      if (due) begin
        best_found_q <= best_found_q | better;
        if (due_cnt_q != 2'd2) begin
          due_cnt_q <= due_cnt_q + 2'd1;
        end
      end

      if (cmd_i.sched || cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign timer_id_o    = out_id_q;
  assign fired_tag_o   = out_tag_q;
  assign status_o      = out_status_q;
  assign last_o        = out_last_q;

endmodule

/* hw/rtl/dtq_checker.sv */
// Port-level checks for the deadline timer queue, bound to the top level.
// Depends on dtq_pkg and deadline_timer_queue.
module dtq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       result_kind_o,
  input logic [dtq_pkg::IdW-1:0]    timer_id_o,
  input logic [dtq_pkg::TagW-1:0]   fired_tag_o,
  input logic                       status_o,
  input logic                       last_o
);

  // A schedule answer is always the only beat of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == dtq_pkg::KindSchedule) |-> last_o)
    else $error("schedule answer without last");

  // Schedule answers carry no tag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == dtq_pkg::KindSchedule) |-> (fired_tag_o == '0))
    else $error("schedule answer with nonzero tag");

  // A full report carries id zero and is never a firing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == dtq_pkg::StatusFull) |->
      (timer_id_o == '0) && (result_kind_o == dtq_pkg::KindSchedule))
    else $error("malformed full report");

  // A stalled beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(timer_id_o) && $stable(last_o))
    else $error("output beat changed while stalled");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_kind_o (result_kind_o),
  .timer_id_o    (timer_id_o),
  .fired_tag_o   (fired_tag_o),
  .status_o      (status_o),
  .last_o        (last_o)
);
